// File: design/xfwt_pkg.sv
// Shared types and constants for the XOR-parity FEC window tracker.
// Holds the word payloads, controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package xfwt_pkg;

   localparam int FIELD_OFF_W = 32;
   localparam int SEG_W       = 16;
   localparam int WIN_W       = 8;
   localparam int IMG_W       = 32;
   localparam int WBYTES_W    = SEG_W + WIN_W;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_BYTES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEC_WINDOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BYTES   = 2'd2;

   localparam logic [SEG_W-1:0] SEGMENT_BYTES_RESET = 16'd1024;
   localparam logic [WIN_W-1:0] FEC_WINDOW_RESET    = 8'd4;
   localparam logic [IMG_W-1:0] IMAGE_BYTES_RESET   = 32'd0;

   localparam logic ACTION_DATA   = 1'b0;
   localparam logic ACTION_PARITY = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [FIELD_OFF_W-1:0] seq_offset;
      logic [SEG_W-1:0]       seg_size;
   } req_payload_type;

   typedef struct packed {
      logic                   accepted;
      logic                   out_of_order;
      logic                   gap_seen;
      logic                   window_realigned;
      logic                   recover;
      logic [FIELD_OFF_W-1:0] missing_offset;
      logic [SEG_W-1:0]       missing_size;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WBYTES,
      ST_CHECK,
      ST_DIV_WINDOW,
      ST_DATA_UPDATE,
      ST_DIV_TAIL,
      ST_PAR_REC,
      ST_DIV_IMAGE,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_WBYTES,
      OP_REALIGN_DIRECT,
      OP_REALIGN_DIV,
      OP_DATA_UPDATE,
      OP_TAIL_DIRECT,
      OP_TAIL_DIV,
      OP_PAR_FINISH,
      OP_PAR_FINISH_REC
   } op_type;

   typedef enum logic [1:0] {
      DIV_SEL_WINDOW,
      DIV_SEL_TAIL,
      DIV_SEL_IMAGE
   } div_sel_type;

   typedef struct packed {
      op_type      op;
      logic        div_start;
      div_sel_type div_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_parity;
      logic past_end;
      logic at_end;
      logic tail_gap;
      logic wbytes_zero;
      logic ds_zero;
      logic rec_cond;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// File: design/xfwt_stream_if.sv
// Valid/ready channel carrying one word of a payload type.
// Used for both the header channel and the result channel; no dependencies.
`timescale 1ns / 1ps

interface xfwt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/xor_fec_window_tracker.sv
// XOR-parity FEC window tracker. Each header word (data segment or parity
// packet) yields exactly one result word. Words are handled one at a time:
// a word is taken in the idle state, and its result is ready once each
// modulo that it needs has run on the shared one-bit-per-cycle remainder
// divider, whose dividend width is the larger of OFFSET_BITS and 32. A data
// word needs at most one modulo (window realignment), a parity word at most
// two (skipped-tail offset and the short final segment). The result sits in
// an output register, so the next header is taken while the previous result
// waits. Configuration writes take effect at once and are meant to be done
// while the block is idle.
`timescale 1ns / 1ps

module xor_fec_window_tracker #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   xfwt_stream_if.sink                      req_port,
   xfwt_stream_if.source                    rsp_port,
   input  logic                             csr_we,
   input  logic [xfwt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xfwt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import xfwt_pkg::*;

   cmd_type         cmd;
   status_type      status;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   req_payload_type req_payload;

   assign req_payload      = req_port.payload;
   assign req_port.ready   = req_ready;
   assign rsp_port.valid   = rsp_valid;
   assign rsp_port.payload = rsp_payload;

   xfwt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   xfwt_datapath #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_ready   (rsp_port.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// File: design/xfwt_divider.sv
// Radix-2 restoring divider that returns the remainder, one bit per cycle.
// Shared by all modulo operations of the tracker datapath; no package use.
`timescale 1ns / 1ps

module xfwt_divider #(
   parameter int DIV_W     = 32,
   parameter int DIVISOR_W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIVISOR_W-1:0] remainder
);
   localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] div_ff;
   logic [DIVISOR_W-1:0] rem_ff;

   logic [DIVISOR_W:0]   rem_shift;
   logic [DIVISOR_W:0]   rem_diff;
   logic [DIVISOR_W-1:0] rem_in;

   // The partial remainder stays below the divisor, so the shifted value
   // is below twice the divisor and one subtraction restores it.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      if (rem_shift >= {1'b0, div_ff}) begin
         rem_in = rem_diff[DIVISOR_W-1:0];
      end else begin
         rem_in = rem_shift[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && (count_ff == '0)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff   <= dividend;
         div_ff   <= divisor;
         rem_ff   <= '0;
         count_ff <= CNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         quo_ff   <= {quo_ff[DIV_W-2:0], 1'b0};
         rem_ff   <= rem_in;
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: design/xfwt_datapath.sv
// Datapath of the FEC window tracker: configuration registers, window state,
// per-word arithmetic, the shared divider and the result register.
// Depends on xfwt_pkg and xfwt_divider.
`timescale 1ns / 1ps

module xfwt_datapath #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [xfwt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [xfwt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  xfwt_pkg::req_payload_type           req_payload,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output xfwt_pkg::rsp_payload_type           rsp_payload,
   input  xfwt_pkg::cmd_type                   cmd,
   output xfwt_pkg::status_type                status
);
   import xfwt_pkg::*;

   localparam int OB    = OFFSET_BITS;
   localparam int DIV_W = (OFFSET_BITS > FIELD_OFF_W) ? OFFSET_BITS : FIELD_OFF_W;
   localparam logic [WBYTES_W-1:0] WMASK = (OFFSET_BITS >= WBYTES_W) ?
      {WBYTES_W{1'b1}} : WBYTES_W'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [OB-1:0] ONE_OFF = OB'(1);

   // Configuration registers.
   logic [SEG_W-1:0] seg_bytes_ff;
   logic [WIN_W-1:0] fec_window_ff;
   logic [IMG_W-1:0] image_bytes_ff;

   // Window state.
   logic [OB-1:0]    next_exp_ff, next_exp_in;
   logic [OB-1:0]    lost_ff, lost_in;
   logic [OB-1:0]    win_start_ff, win_start_in;
   logic [WIN_W-1:0] sic_ff, sic_in;

   // Current word and its partial result.
   logic                action_ff, action_in;
   logic [OB-1:0]       seqn_ff, seqn_in;
   logic [SEG_W-1:0]    size_ff, size_in;
   logic [WBYTES_W-1:0] wbytes_ff, wbytes_in;
   logic                acc_ff, acc_in;
   logic                ooo_ff, ooo_in;
   logic                gap_ff, gap_in;
   logic                realign_ff, realign_in;
   logic                rec_ff, rec_in;
   logic [SEG_W-1:0]    msize_ff, msize_in;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [DIV_W-1:0]    seq_ext;
   logic [WBYTES_W-1:0] wbytes_prod;
   logic [OB-1:0]       wend;
   logic [OB-1:0]       rem_off;
   logic [OB-1:0]       realign_ws;
   logic [OB-1:0]       tail_x;
   logic [OB-1:0]       tail_lost;
   logic [OB-1:0]       data_next;
   logic [IMG_W-1:0]    img_last;
   logic [DIV_W-1:0]    lost_ext;
   logic [DIV_W-1:0]    last_ext;
   logic [SEG_W-1:0]    msize_rec;
   logic                rec_cond;

   logic [DIV_W-1:0]    div_dividend;
   logic [WBYTES_W-1:0] div_divisor;
   logic                div_done;
   logic [WBYTES_W-1:0] div_rem;

   xfwt_divider #(
      .DIV_W     (DIV_W),
      .DIVISOR_W (WBYTES_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_bytes_ff   <= SEGMENT_BYTES_RESET;
         fec_window_ff  <= FEC_WINDOW_RESET;
         image_bytes_ff <= IMAGE_BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEGMENT_BYTES: seg_bytes_ff   <= csr_wdata[SEG_W-1:0];
            CSR_FEC_WINDOW:    fec_window_ff  <= csr_wdata[WIN_W-1:0];
            CSR_IMAGE_BYTES:   image_bytes_ff <= csr_wdata[IMG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      seq_ext     = DIV_W'(req_payload.seq_offset);
      wbytes_prod = WBYTES_W'(seg_bytes_ff) * WBYTES_W'(fec_window_ff);
      wend        = win_start_ff + OB'(wbytes_ff);
      rem_off     = OB'(div_rem);
      realign_ws  = seqn_ff - rem_off;
      tail_x      = seqn_ff - next_exp_ff - ONE_OFF;
      // Last segment start below the parity offset: (x - x mod ds) past next_expected.
      tail_lost   = seqn_ff - ONE_OFF - rem_off;
      data_next   = seqn_ff + OB'(size_ff);
      img_last    = image_bytes_ff - IMG_W'(div_rem);
      lost_ext    = DIV_W'(lost_ff);
      last_ext    = DIV_W'(img_last);
      msize_rec   = (lost_ext == last_ext) ? SEG_W'(div_rem) : seg_bytes_ff;
      rec_cond    = (fec_window_ff != '0) && (seqn_ff == next_exp_ff) &&
                    (sic_ff == (fec_window_ff - WIN_W'(1)));
   end

   always_comb begin
      unique case (cmd.div_sel)
         DIV_SEL_WINDOW: begin
            div_dividend = DIV_W'(seqn_ff);
            div_divisor  = wbytes_ff;
         end
         DIV_SEL_TAIL: begin
            div_dividend = DIV_W'(tail_x);
            div_divisor  = WBYTES_W'(seg_bytes_ff);
         end
         DIV_SEL_IMAGE: begin
            div_dividend = DIV_W'(image_bytes_ff);
            div_divisor  = WBYTES_W'(seg_bytes_ff);
         end
         default: begin
            div_dividend = DIV_W'(seqn_ff);
            div_divisor  = wbytes_ff;
         end
      endcase
   end

   always_comb begin
      next_exp_in  = next_exp_ff;
      lost_in      = lost_ff;
      win_start_in = win_start_ff;
      sic_in       = sic_ff;
      action_in    = action_ff;
      seqn_in      = seqn_ff;
      size_in      = size_ff;
      wbytes_in    = wbytes_ff;
      acc_in       = acc_ff;
      ooo_in       = ooo_ff;
      gap_in       = gap_ff;
      realign_in   = realign_ff;
      rec_in       = rec_ff;
      msize_in     = msize_ff;

      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            action_in  = req_payload.action;
            seqn_in    = seq_ext[OB-1:0];
            size_in    = req_payload.seg_size;
            acc_in     = 1'b0;
            ooo_in     = 1'b0;
            gap_in     = 1'b0;
            realign_in = 1'b0;
            rec_in     = 1'b0;
            msize_in   = '0;
         end
         OP_WBYTES: begin
            wbytes_in = wbytes_prod & WMASK;
         end
         OP_REALIGN_DIRECT: begin
            realign_in   = 1'b1;
            win_start_in = seqn_ff;
            next_exp_in  = seqn_ff;
            sic_in       = '0;
         end
         OP_REALIGN_DIV: begin
            realign_in   = 1'b1;
            win_start_in = realign_ws;
            next_exp_in  = realign_ws;
            sic_in       = '0;
         end
         OP_DATA_UPDATE: begin
            if (seqn_ff < next_exp_ff) begin
               ooo_in = 1'b1;
            end else begin
               if (seqn_ff > next_exp_ff) begin
                  gap_in  = 1'b1;
                  lost_in = next_exp_ff;
               end
               acc_in      = 1'b1;
               sic_in      = sic_ff + WIN_W'(1);
               next_exp_in = data_next;
            end
         end
         OP_TAIL_DIRECT: begin
            if (next_exp_ff < seqn_ff) begin
               gap_in  = 1'b1;
               lost_in = next_exp_ff;
            end
            next_exp_in = seqn_ff;
         end
         OP_TAIL_DIV: begin
            gap_in      = 1'b1;
            lost_in     = tail_lost;
            next_exp_in = seqn_ff;
         end
         OP_PAR_FINISH: begin
            rec_in       = rec_cond;
            sic_in       = '0;
            next_exp_in  = seqn_ff;
            win_start_in = seqn_ff;
         end
         OP_PAR_FINISH_REC: begin
            rec_in       = 1'b1;
            msize_in     = msize_rec;
            sic_in       = '0;
            next_exp_in  = seqn_ff;
            win_start_in = seqn_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_exp_ff  <= '0;
         lost_ff      <= '0;
         win_start_ff <= '0;
         sic_ff       <= '0;
      end else begin
         next_exp_ff  <= next_exp_in;
         lost_ff      <= lost_in;
         win_start_ff <= win_start_in;
         sic_ff       <= sic_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      seqn_ff    <= seqn_in;
      size_ff    <= size_in;
      wbytes_ff  <= wbytes_in;
      acc_ff     <= acc_in;
      ooo_ff     <= ooo_in;
      gap_ff     <= gap_in;
      realign_ff <= realign_in;
      rec_ff     <= rec_in;
      msize_ff   <= msize_in;
   end

   always_comb begin
      rsp_payload_in.accepted         = acc_ff;
      rsp_payload_in.out_of_order     = ooo_ff;
      rsp_payload_in.gap_seen         = gap_ff;
      rsp_payload_in.window_realigned = realign_ff;
      rsp_payload_in.recover          = rec_ff;
      rsp_payload_in.missing_offset   = rec_ff ? lost_ext[FIELD_OFF_W-1:0] : '0;
      rsp_payload_in.missing_size     = msize_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      status.is_parity   = (action_ff == ACTION_PARITY);
      status.past_end    = (seqn_ff >= wend);
      status.at_end      = (seqn_ff == wend);
      status.tail_gap    = (next_exp_ff < seqn_ff);
      status.wbytes_zero = (wbytes_ff == '0);
      status.ds_zero     = (seg_bytes_ff == '0);
      status.rec_cond    = rec_cond;
      status.div_done    = div_done;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: design/xfwt_controller.sv
// Sequencer of the FEC window tracker: takes a header word, steps the
// datapath through its operations and hands the result to the output register.
// Depends on xfwt_pkg.
`timescale 1ns / 1ps

module xfwt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  xfwt_pkg::status_type status,
   output xfwt_pkg::cmd_type    cmd
);
   import xfwt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.op        = OP_NONE;
      cmd.div_start = 1'b0;
      cmd.div_sel   = DIV_SEL_WINDOW;
      cmd.rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_WBYTES;
            end
         end
         ST_WBYTES: begin
            cmd.op   = OP_WBYTES;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.is_parity) begin
               if (status.past_end && status.wbytes_zero) begin
                  cmd.op   = OP_REALIGN_DIRECT;
                  state_in = ST_DATA_UPDATE;
               end else if (status.past_end) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_SEL_WINDOW;
                  state_in      = ST_DIV_WINDOW;
               end else begin
                  state_in = ST_DATA_UPDATE;
               end
            end else begin
               if (status.at_end && status.tail_gap && !status.ds_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_SEL_TAIL;
                  state_in      = ST_DIV_TAIL;
               end else if (status.at_end) begin
                  cmd.op   = OP_TAIL_DIRECT;
                  state_in = ST_PAR_REC;
               end else begin
                  state_in = ST_PAR_REC;
               end
            end
         end
         ST_DIV_WINDOW: begin
            cmd.div_sel = DIV_SEL_WINDOW;
            if (status.div_done) begin
               cmd.op   = OP_REALIGN_DIV;
               state_in = ST_DATA_UPDATE;
            end
         end
         ST_DATA_UPDATE: begin
            cmd.op   = OP_DATA_UPDATE;
            state_in = ST_DONE;
         end
         ST_DIV_TAIL: begin
            cmd.div_sel = DIV_SEL_TAIL;
            if (status.div_done) begin
               cmd.op   = OP_TAIL_DIV;
               state_in = ST_PAR_REC;
            end
         end
         ST_PAR_REC: begin
            // The final segment may be short, which needs image_bytes mod segment_bytes.
            if (status.rec_cond && !status.ds_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_IMAGE;
               state_in      = ST_DIV_IMAGE;
            end else begin
               cmd.op   = OP_PAR_FINISH;
               state_in = ST_DONE;
            end
         end
         ST_DIV_IMAGE: begin
            cmd.div_sel = DIV_SEL_IMAGE;
            if (status.div_done) begin
               cmd.op   = OP_PAR_FINISH_REC;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: verif/xfwt_window_checker.sv
// Checker for the XOR-parity FEC window tracker: predicts each result word from the
// accepted header words and compares it with what the block returns.
// Depends on xfwt_pkg for the payload types, register indexes and reset values.
`timescale 1ns / 1ps

module xfwt_window_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  xfwt_pkg::req_payload_type        req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  xfwt_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_we,
   input  logic [xfwt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xfwt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               outstanding
);
   import xfwt_pkg::*;

   logic [SEG_W-1:0]       seg_bytes;
   logic [WIN_W-1:0]       win_segs;
   logic [IMG_W-1:0]       img_bytes;
   logic [FIELD_OFF_W-1:0] next_off;
   logic [FIELD_OFF_W-1:0] lost_off;
   logic [FIELD_OFF_W-1:0] win_base;
   logic [7:0]             seg_count;

   rsp_payload_type window_outcomes[$];
   int                words_checked = 0;
   int                error_total = 0;

   assign mismatches = error_total;

   // Window bookkeeping for one header word; returns the result word it should cause.
   function automatic rsp_payload_type track_header(input req_payload_type hdr);
      rsp_payload_type        res;
      logic [FIELD_OFF_W-1:0] off;
      logic [FIELD_OFF_W-1:0] wbytes;
      logic [FIELD_OFF_W-1:0] wend;
      logic [IMG_W-1:0]       last_start;
      res = '0;
      off = hdr.seq_offset;
      wbytes = 32'(seg_bytes) * 32'(win_segs);
      wend = win_base + wbytes;
      if (hdr.action == ACTION_DATA) begin
         // A data word at or past the window end means the parity word was lost.
         if (off >= wend) begin
            res.window_realigned = 1'b1;
            seg_count = '0;
            win_base = (wbytes != 0) ? off - off % wbytes : off;
            next_off = win_base;
         end
         res.accepted = 1'b1;
         if (off > next_off) begin
            res.gap_seen = 1'b1;
            lost_off = next_off;
         end else if (off < next_off) begin
            res.out_of_order = 1'b1;
            res.accepted = 1'b0;
         end
         if (res.accepted) begin
            seg_count = seg_count + 8'd1;
            next_off = off + 32'(hdr.seg_size);
         end
      end else begin
         if (off == wend) begin
            // Segments skipped at the window tail: the last one before the parity
            // word is the one that counts as lost.
            if (next_off < off) begin
               res.gap_seen = 1'b1;
               if (seg_bytes != 0)
                  lost_off = next_off + ((off - 32'd1 - next_off) / 32'(seg_bytes))
                             * 32'(seg_bytes);
               else
                  lost_off = next_off;
            end
            next_off = wend;
         end
         if (win_segs != 0 && off == next_off && seg_count == win_segs - 8'd1) begin
            res.recover = 1'b1;
            res.missing_offset = lost_off;
            if (seg_bytes != 0) begin
               last_start = img_bytes - img_bytes % 32'(seg_bytes);
               res.missing_size = (lost_off == last_start) ? 16'(img_bytes - last_start)
                                                           : seg_bytes;
            end
         end
         seg_count = '0;
         next_off = off;
         win_base = off;
      end
      return res;
   endfunction

   function automatic void compare_field(input string label, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: result word %0d, %s expected %0h actual %0h",
                  $time, words_checked, label, want, got);
         error_total++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         seg_bytes = SEGMENT_BYTES_RESET;
         win_segs = FEC_WINDOW_RESET;
         img_bytes = IMAGE_BYTES_RESET;
         next_off = '0;
         lost_off = '0;
         win_base = '0;
         seg_count = '0;
         window_outcomes.delete();
      end else begin
         // Results are checked before new headers are queued, so a result can
         // never be matched against the header taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (window_outcomes.size() == 0) begin
               $display("%0t: result word %0d expected none actual %h",
                        $time, words_checked, rsp_payload);
               error_total++;
            end else begin
               want = window_outcomes.pop_front();
               compare_field("accepted", 32'(want.accepted), 32'(rsp_payload.accepted));
               compare_field("out_of_order", 32'(want.out_of_order),
                             32'(rsp_payload.out_of_order));
               compare_field("gap_seen", 32'(want.gap_seen), 32'(rsp_payload.gap_seen));
               compare_field("window_realigned", 32'(want.window_realigned),
                             32'(rsp_payload.window_realigned));
               compare_field("recover", 32'(want.recover), 32'(rsp_payload.recover));
               compare_field("missing_offset", want.missing_offset,
                             rsp_payload.missing_offset);
               compare_field("missing_size", 32'(want.missing_size),
                             32'(rsp_payload.missing_size));
            end
            words_checked++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SEGMENT_BYTES: seg_bytes = csr_wdata[SEG_W-1:0];
               CSR_FEC_WINDOW:    win_segs = csr_wdata[WIN_W-1:0];
               CSR_IMAGE_BYTES:   img_bytes = csr_wdata[IMG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            window_outcomes.push_back(track_header(req_payload));
      end
      outstanding <= window_outcomes.size();
   end

endmodule

// File: verif/xor_fec_window_tracker_test.sv
// Top of the FEC window tracker testbench: clock, reset, register writes and header
// stimulus, result-side back-pressure and the verdict.
// Depends on xfwt_pkg, xfwt_stream_if, the tracker itself and xfwt_window_checker.
`timescale 1ns / 1ps

module xor_fec_window_tracker_test;
   import xfwt_pkg::*;

   localparam int TOTAL_WORDS  = 1320;
   localparam int QUIET_FROM   = 1200;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int          words_sent = 0;
   int          gap_odds = 0;
   int          cycle_count = 0;
   int          mismatches;
   int          outstanding;
   bit          quiet = 1'b0;
   bit          hold_armed = 1'b0;
   bit          long_hold_req = 1'b0;
   logic [63:0] stream_pos = '0;

   xfwt_stream_if #(.payload_type(req_payload_type)) req_ch ();
   xfwt_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   xor_fec_window_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   xfwt_window_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: short random stalls, one long hold-off on request so that the
   // block backs up into the header channel, and no stalls near the end.
   initial begin
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_word(input logic kind, input logic [31:0] off,
                            input logic [15:0] size);
      if (gap_odds != 0 && !quiet && $urandom_range(0, 9) < gap_odds) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= {kind, off, size};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      quiet = (words_sent >= QUIET_FROM);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic drain;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One transfer under one register setting: windows of consecutive segments with
   // losses, swaps, duplicates, lost parity words and stray words, or, when the
   // window spans no bytes, a free-running stream of offsets.
   task automatic run_phase(input logic [15:0] ds, input logic [7:0] fw, input int nwin,
                            input bit wrap);
      logic [31:0] wbytes;
      logic [31:0] base;
      logic [31:0] wbase;
      logic [31:0] img;
      logic [31:0] cur;
      logic [31:0] last_off;
      logic [31:0] off;
      logic [63:0] aligned;
      logic [15:0] short_len;
      logic [15:0] size;
      int          mode;
      int          drop_a;
      int          drop_b;
      int          swap_at;
      int          seg;
      wbytes = 32'(ds) * 32'(fw);
      short_len = (ds > 1) ? 16'($urandom_range(0, ds - 1)) : 16'd0;
      if (wbytes == 0) begin
         base = stream_pos[31:0];
         img = $urandom;
      end else begin
         aligned = ((stream_pos + 64'(wbytes) - 64'd1) / 64'(wbytes)) * 64'(wbytes);
         if (wrap) begin
            aligned = 64'(32'd0 - 32'd2 * wbytes);
            short_len = 16'd1;
         end
         base = aligned[31:0];
         // The last segment of the transfer may be short, which shortens its rebuild.
         img = base + 32'(nwin) * wbytes - 32'(short_len);
         stream_pos = aligned + 64'(nwin) * 64'(wbytes);
      end
      csr_write(CSR_SEGMENT_BYTES, 32'(ds));
      csr_write(CSR_FEC_WINDOW, 32'(fw));
      csr_write(CSR_IMAGE_BYTES, img);
      csr_we <= 1'b0;
      gap_odds = $urandom_range(0, 3);
      if (wbytes == 0) begin
         cur = base;
         last_off = base;
         for (int i = 0; i < nwin * 4; i++) begin
            mode = $urandom_range(0, 5);
            case (mode)
               0: send_word(ACTION_PARITY, ($urandom_range(0, 1) == 0) ? last_off : cur,
                            16'($urandom));
               1: send_word(ACTION_PARITY, cur + 32'($urandom_range(1, 4000)),
                            16'($urandom));
               2: begin
                  // A segment that runs past the top of the offset space leaves the
                  // next offset below the window start.
                  off = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
                  send_word(ACTION_DATA, off, 16'($urandom_range(256, 4096)));
                  send_word(ACTION_PARITY, off, 16'd0);
                  send_word(ACTION_PARITY, cur, 16'd0);
               end
               3: send_word(ACTION_DATA, last_off, 16'($urandom_range(0, 2000)));
               default: begin
                  size = 16'($urandom_range(0, 2000));
                  send_word(ACTION_DATA, cur, size);
                  last_off = cur;
                  cur = cur + 32'(size);
               end
            endcase
         end
         stream_pos = 64'(cur);
      end else begin
         for (int w = 0; w < nwin; w++) begin
            wbase = base + 32'(w) * wbytes;
            if (hold_armed && w == 2) begin
               hold_armed = 1'b0;
               long_hold_req = 1'b1;
            end
            if ($urandom_range(0, 11) == 0)
               send_word(1'($urandom_range(0, 1)), $urandom, 16'($urandom));
            mode = $urandom_range(0, 9);
            drop_a = fw;
            drop_b = fw;
            if (mode < 4) begin
               drop_a = $urandom_range(0, fw - 1);
            end else if (mode == 4) begin
               drop_a = $urandom_range(0, fw - 1);
               drop_b = $urandom_range(0, fw - 1);
            end
            swap_at = (mode == 5 && fw > 1) ? $urandom_range(0, fw - 2) : -1;
            for (int k = 0; k < fw; k++) begin
               seg = k;
               if (swap_at >= 0 && k == swap_at)
                  seg = k + 1;
               else if (swap_at >= 0 && k == swap_at + 1)
                  seg = k - 1;
               if (seg == drop_a || seg == drop_b)
                  continue;
               off = wbase + 32'(seg) * 32'(ds);
               size = (w == nwin - 1 && seg == fw - 1) ? ds - short_len : ds;
               send_word(ACTION_DATA, off, size);
               if (mode == 6 && k == 0)
                  send_word(ACTION_DATA, off, size);
            end
            // Now and then the parity word goes missing.
            if ($urandom_range(0, 9) != 0)
               send_word(ACTION_PARITY, wbase + wbytes, 16'($urandom));
         end
      end
      req_ch.valid <= 1'b0;
      drain();
   endtask

   initial begin
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 1024-byte segments, four per window, empty image.
      gap_odds = 2;
      send_word(ACTION_DATA, 32'd0, 16'd1024);
      send_word(ACTION_DATA, 32'd2048, 16'd1024);
      send_word(ACTION_DATA, 32'd1024, 16'd1024);
      send_word(ACTION_DATA, 32'd3072, 16'd1024);
      send_word(ACTION_PARITY, 32'd4096, 16'd0);
      send_word(ACTION_DATA, 32'd4096, 16'd1024);
      send_word(ACTION_DATA, 32'd5120, 16'd1024);
      send_word(ACTION_DATA, 32'd6144, 16'd1024);
      send_word(ACTION_PARITY, 32'd8192, 16'd0);
      send_word(ACTION_DATA, 32'd20000, 16'd1024);
      send_word(ACTION_DATA, 32'd16384, 16'd1024);
      send_word(ACTION_DATA, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(ACTION_DATA, 32'd0, 16'd0);
      send_word(ACTION_PARITY, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(ACTION_PARITY, 32'd0, 16'h8000);
      req_ch.valid <= 1'b0;
      drain();

      run_phase(16'd1, 8'd1, 30, 1'b0);
      run_phase(16'hFFFF, 8'hFF, 1, 1'b0);
      run_phase(16'd0, 8'd1, 10, 1'b0);
      run_phase(16'd1500, 8'd0, 10, 1'b0);
      run_phase(16'd1024, 8'd4, 4, 1'b1);

      hold_armed = 1'b1;
      while (words_sent < TOTAL_WORDS)
         run_phase(($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 16))
                                               : 16'($urandom_range(64, 4096)),
                   8'($urandom_range(1, 12)), $urandom_range(4, 12), 1'b0);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
